// ----- rtl/core/lcdseq_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, codes and constants of the character LCD bus sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

   localparam int CHARS_PER_LINE_DEF = 16;

   localparam int CsrDataW = 10;
   localparam int CsrAddrW = 2;
   localparam int ReqDataW = 24;
   localparam int RspDataW = 16;

   localparam logic [CsrAddrW-1:0] CSR_STROBE_TICKS = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_BUSY_LIMIT   = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_SECOND_LINE  = 2'd2;

   localparam logic [9:0] STROBE_TICKS_RESET = 10'd10;
   localparam logic [9:0] BUSY_LIMIT_RESET   = 10'd100;
   localparam logic [6:0] SECOND_LINE_RESET  = 7'd44;

   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_INIT  = 3'd1;
   localparam logic [2:0] KIND_INSTR = 3'd2;
   localparam logic [2:0] KIND_LINE  = 3'd3;
   localparam logic [2:0] KIND_CHAR  = 3'd4;
   localparam logic [2:0] KIND_CONT  = 3'd5;

   // Step codes used by the init and continuous character requests.
   localparam logic [2:0] STEP_FIRST     = 3'd0;
   localparam logic [2:0] STEP_LINE_WR   = 3'd1;
   localparam logic [2:0] STEP_CHAR_WR   = 3'd2;
   localparam logic [2:0] STEP_INIT_LAST = 3'd3;
   localparam logic [2:0] STEP_DROPPED   = 3'd7;

   localparam logic [7:0] DDRAM_SET = 8'h80;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_POLL_SETUP,
      PH_POLL_STROBE,
      PH_WR_SETUP,
      PH_WR_STROBE,
      PH_FINISH
   } phase_type;

   typedef struct packed {
      logic [9:0] strobe_ticks;
      logic [9:0] busy_limit;
      logic [6:0] second_line_address;
   } cfg_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data_byte;
      logic       second_line;
      logic [7:0] bus_in;
   } req_type;

   typedef struct packed {
      logic       dropped;
      logic       done_res;
      logic       ready_res;
      logic       drive_data;
      logic [7:0] lcd_data;
      logic       lcd_enable;
      logic       lcd_rw;
      logic       lcd_rs;
   } rsp_type;

   // Power-up instruction sequence: function set, display on, entry mode, clear.
   function automatic logic [7:0] init_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = 8'h38;
         2'd1: b = 8'h0C;
         2'd2: b = 8'h06;
         default: b = 8'h01;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/core/lcdseq_core.sv -----
// ----------------------------------------------------------------------------
// lcdseq_core
// Sequencer state and the single-tick step: pin levels and next state.
// ----------------------------------------------------------------------------
module lcdseq_core #(
   parameter int CHARS_PER_LINE = lcdseq_pkg::CHARS_PER_LINE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  lcdseq_pkg::req_type req,
   input  lcdseq_pkg::cfg_type cfg,
   output lcdseq_pkg::rsp_type res
);

   localparam int CharW = $clog2(2 * CHARS_PER_LINE + 1);
   localparam logic [CharW-1:0] CharFull = CharW'(2 * CHARS_PER_LINE);
   localparam logic [CharW-1:0] CharLine = CharW'(CHARS_PER_LINE);

   lcdseq_pkg::phase_type phase_ff, phase_in;
   logic [9:0]       tick_ff, tick_in;
   logic [9:0]       poll_ff, poll_in;
   logic [CharW-1:0] char_ff, char_in;
   logic [2:0]       kind_ff, kind_in;
   logic [7:0]       held_ff, held_in;
   logic [2:0]       step_ff, step_in;

   logic [9:0] strobe_len;
   logic [9:0] poll_max;
   logic [9:0] poll_inc;
   logic       strobe_more;
   logic [7:0] wr_byte;
   logic       wr_rs;

   assign strobe_len  = (cfg.strobe_ticks == 10'd0) ? 10'd1 : cfg.strobe_ticks;
   assign poll_max    = (cfg.busy_limit == 10'd0) ? 10'd1 : cfg.busy_limit;
   assign poll_inc    = poll_ff + 10'd1;
   assign strobe_more = ({1'b0, tick_ff} + 11'd1) < {1'b0, strobe_len};

   always_comb begin
      wr_rs   = 1'b0;
      wr_byte = held_ff;
      case (kind_ff)
         lcdseq_pkg::KIND_INIT: begin
            wr_byte = lcdseq_pkg::init_byte(step_ff[1:0]);
         end
         lcdseq_pkg::KIND_CHAR: begin
            wr_rs = 1'b1;
         end
         lcdseq_pkg::KIND_CONT: begin
            if (step_ff == lcdseq_pkg::STEP_LINE_WR) begin
               wr_byte = lcdseq_pkg::DDRAM_SET | {1'b0, cfg.second_line_address};
            end else begin
               wr_rs = 1'b1;
            end
         end
         default: begin
            wr_byte = held_ff;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      poll_in  = poll_ff;
      char_in  = char_ff;
      kind_in  = kind_ff;
      held_in  = held_ff;
      step_in  = step_ff;
      res      = '0;
      res.drive_data = 1'b1;

      case (phase_ff)
         lcdseq_pkg::PH_POLL_SETUP: begin
            res.lcd_rw     = 1'b1;
            res.drive_data = 1'b0;
            tick_in        = '0;
            phase_in       = lcdseq_pkg::PH_POLL_STROBE;
         end
         lcdseq_pkg::PH_POLL_STROBE: begin
            res.lcd_rw     = 1'b1;
            res.lcd_enable = 1'b1;
            res.drive_data = 1'b0;
            if (strobe_more) begin
               tick_in = tick_ff + 10'd1;
            end else begin
               tick_in = '0;
               poll_in = poll_inc;
               if (req.bus_in[7] && (poll_inc < poll_max)) begin
                  phase_in = lcdseq_pkg::PH_POLL_SETUP;
               end else if (kind_ff == lcdseq_pkg::KIND_CONT &&
                            step_ff == lcdseq_pkg::STEP_FIRST) begin
                  // The screen-full check happens only once the busy poll ends (ready or poll limit).
                  if (char_ff >= CharFull) begin
                     step_in  = lcdseq_pkg::STEP_DROPPED;
                     phase_in = lcdseq_pkg::PH_FINISH;
                  end else begin
                     step_in  = (char_ff == CharLine) ? lcdseq_pkg::STEP_LINE_WR
                                                      : lcdseq_pkg::STEP_CHAR_WR;
                     phase_in = lcdseq_pkg::PH_WR_SETUP;
                  end
               end else begin
                  phase_in = lcdseq_pkg::PH_WR_SETUP;
               end
            end
         end
         lcdseq_pkg::PH_WR_SETUP: begin
            res.lcd_rs   = wr_rs;
            res.lcd_data = wr_byte;
            tick_in      = '0;
            phase_in     = lcdseq_pkg::PH_WR_STROBE;
         end
         lcdseq_pkg::PH_WR_STROBE: begin
            res.lcd_rs     = wr_rs;
            res.lcd_data   = wr_byte;
            res.lcd_enable = 1'b1;
            if (strobe_more) begin
               tick_in = tick_ff + 10'd1;
            end else begin
               tick_in = '0;
               if (kind_ff == lcdseq_pkg::KIND_INIT && step_ff < lcdseq_pkg::STEP_INIT_LAST)
               begin
                  step_in  = step_ff + 3'd1;
                  poll_in  = '0;
                  phase_in = lcdseq_pkg::PH_POLL_SETUP;
               end else if (kind_ff == lcdseq_pkg::KIND_CONT &&
                            step_ff == lcdseq_pkg::STEP_LINE_WR) begin
                  step_in  = lcdseq_pkg::STEP_CHAR_WR;
                  poll_in  = '0;
                  phase_in = lcdseq_pkg::PH_POLL_SETUP;
               end else begin
                  if (kind_ff == lcdseq_pkg::KIND_INIT) begin
                     char_in = '0;
                  end else if (kind_ff == lcdseq_pkg::KIND_CONT && char_ff < CharFull) begin
                     char_in = char_ff + CharW'(1);
                  end
                  phase_in = lcdseq_pkg::PH_FINISH;
               end
            end
         end
         lcdseq_pkg::PH_FINISH: begin
            res.done_res = 1'b1;
            res.dropped  = (step_ff == lcdseq_pkg::STEP_DROPPED);
            step_in      = lcdseq_pkg::STEP_FIRST;
            phase_in     = lcdseq_pkg::PH_IDLE;
         end
         default: begin
            res.ready_res = 1'b1;
            phase_in      = lcdseq_pkg::PH_IDLE;
            if (req.cmd inside {[lcdseq_pkg::KIND_INIT:lcdseq_pkg::KIND_CONT]}) begin
               kind_in = req.cmd;
               step_in = lcdseq_pkg::STEP_FIRST;
               if (req.cmd == lcdseq_pkg::KIND_LINE) begin
                  held_in = lcdseq_pkg::DDRAM_SET |
                            {1'b0, req.second_line ? cfg.second_line_address : 7'd0};
               end else begin
                  held_in = req.data_byte;
               end
               tick_in  = '0;
               poll_in  = '0;
               phase_in = lcdseq_pkg::PH_POLL_SETUP;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lcdseq_pkg::PH_IDLE;
         tick_ff  <= '0;
         poll_ff  <= '0;
         char_ff  <= '0;
         kind_ff  <= lcdseq_pkg::KIND_NONE;
         held_ff  <= '0;
         step_ff  <= lcdseq_pkg::STEP_FIRST;
      end else if (step_en) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         poll_ff  <= poll_in;
         char_ff  <= char_in;
         kind_ff  <= kind_in;
         held_ff  <= held_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- rtl/core/char_lcd_interface_sequencer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_interface_sequencer
// A request transfer passes the input register, the core step and the result register.
// Throughput: one tick per cycle when not stalled, set by the single-pass step in lcdseq_core.
// Input and result registers part the two streams, so stalls do not lose ticks.
// Reset (synchronous) clears both streams, restores register defaults and
// returns the sequencer to idle with all counters cleared.
// ----------------------------------------------------------------------------
module char_lcd_interface_sequencer #(
   parameter int CHARS_PER_LINE = lcdseq_pkg::CHARS_PER_LINE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // csr port
   input  logic                            csr_we,
   input  logic [lcdseq_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [lcdseq_pkg::CsrDataW-1:0] csr_wdata,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lcdseq_pkg::ReqDataW-1:0] req_tdata,  // data_byte, second_line, bus_in
   input  logic [2:0]                      req_tuser,  // cmd
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // lcd_rs, lcd_rw, lcd_enable, lcd_data, drive_data, ready_res, done_res, dropped
   output logic [lcdseq_pkg::RspDataW-1:0] rsp_tdata
);

   lcdseq_pkg::cfg_type cfg_ff;
   lcdseq_pkg::req_type in_data_ff;
   lcdseq_pkg::rsp_type step_res;
   lcdseq_pkg::rsp_type out_data_ff;
   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic advance;
   logic step_en;
   logic req_take;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = step_en || (out_valid_ff && !rsp_tready);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strobe_ticks        <= lcdseq_pkg::STROBE_TICKS_RESET;
         cfg_ff.busy_limit          <= lcdseq_pkg::BUSY_LIMIT_RESET;
         cfg_ff.second_line_address <= lcdseq_pkg::SECOND_LINE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            lcdseq_pkg::CSR_STROBE_TICKS: cfg_ff.strobe_ticks <= csr_wdata;
            lcdseq_pkg::CSR_BUSY_LIMIT:   cfg_ff.busy_limit   <= csr_wdata;
            lcdseq_pkg::CSR_SECOND_LINE:  cfg_ff.second_line_address <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff.cmd         <= req_tuser;
         in_data_ff.data_byte   <= req_tdata[7:0];
         in_data_ff.second_line <= req_tdata[8];
         in_data_ff.bus_in      <= req_tdata[16:9];
      end
      if (step_en) begin
         out_data_ff <= step_res;
      end
   end

   lcdseq_core #(
      .CHARS_PER_LINE(CHARS_PER_LINE)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step_en(step_en),
      .req    (in_data_ff),
      .cfg    (cfg_ff),
      .res    (step_res)
   );

endmodule

// ----- rtl/core/lcdseq_checker.sv -----
// ----------------------------------------------------------------------------
// lcdseq_checker
// Port-level checks of the result stream of the LCD sequencer.
// ----------------------------------------------------------------------------
module lcdseq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lcdseq_pkg::RspDataW-1:0] rsp_tdata
);

   // A stalled result transfer keeps its pin levels.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Idle ticks leave the bus quiet and driven, and never finish a request.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |->
         !rsp_tdata[2] && !rsp_tdata[1] && rsp_tdata[11] && !rsp_tdata[13])
      else $error("idle tick with bus activity");

   // A drop is reported only on a finish tick, and a finish tick has E low.
   a_drop_on_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[14] |-> rsp_tdata[13] && !rsp_tdata[2])
      else $error("drop pulse outside finish tick");

   // The tick after a finish is always idle.
   a_finish_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata[13] ##1 rsp_tvalid |-> rsp_tdata[12])
      else $error("finish not followed by idle tick");

endmodule

bind char_lcd_interface_sequencer lcdseq_checker u_lcdseq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
